// ===== hdl/gmc_pkg.sv =====
`default_nettype none

package gmc_pkg;

	// Field widths
	localparam int unsigned CNT_W  = 31;
	localparam int unsigned YEAR_W = 13;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned MIN_W  = 6;

	// Pipeline depth, from item accept to result register
	localparam int unsigned NSTG = 10;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} gmc_op_t;

	typedef struct packed {
		logic [NSTG-1:0] adv;       // stage k+1 register loads when adv[k]
		logic            out_valid;
		logic            out_op;
	} gmc_ctl_t;

	// Calendar constants
	localparam int unsigned DAYS_4Y       = 1461;
	localparam int unsigned DAY_OFFSET    = 32075;
	localparam int unsigned MIN_PER_DAY   = 1440;
	localparam int unsigned MIN_PER_HOUR  = 60;
	localparam int unsigned JD_BIAS       = 68569;
	localparam int unsigned DAYS_400Y     = 146097;
	localparam int unsigned DAYS_4000Y    = 1461001;
	localparam int unsigned MONTH_DEN     = 2447;
	localparam int unsigned MONTH_NUM     = 80;
	localparam int unsigned YEAR_SHIFT    = 6400;
	localparam int unsigned EPOCH_YEAR    = 1600;
	localparam int unsigned CENT_YEAR     = EPOCH_YEAR - 100;
	localparam int unsigned DEC_YEAR_BASE = YEAR_SHIFT - 49 * 100;
	localparam int unsigned DAY_BIAS      = 31;
	localparam int unsigned YEAR_MONTHS   = 12;
	localparam int unsigned MONTH_WRAP    = 11;
	localparam int unsigned ENC_YEAR      = 1700;
	localparam int unsigned CENTURY       = 100;
	localparam int unsigned Y400_MUL      = 4000;

	// 1440 = 45 << 5: shift first, then divide the narrower value by 45
	localparam int unsigned DAY_SHIFT = 5;
	localparam int unsigned DAY_ODD   = MIN_PER_DAY >> DAY_SHIFT;

	// Reciprocal constants: floor(C*v/D) = (v * ceil(C*2^S/D)) >> S, valid while v*D < 2^S.
	// minutes / 1440
	localparam int unsigned Q45_VW = CNT_W - DAY_SHIFT;
	localparam int unsigned Q45_S  = 32;
	localparam int unsigned Q45_MW = 27;
	localparam int unsigned Q45_PW = Q45_VW + Q45_MW;
	localparam logic [Q45_MW-1:0] Q45_M =
		Q45_MW'(((64'd1 << Q45_S) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
	// 4*l / 146097
	localparam int unsigned QN_VW = 21;
	localparam int unsigned QN_S  = 39;
	localparam int unsigned QN_MW = 24;
	localparam int unsigned QN_PW = QN_VW + QN_MW;
	localparam logic [QN_MW-1:0] QN_M =
		QN_MW'(((64'd4 << QN_S) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
	// 4000*(l+1) / 1461001
	localparam int unsigned QI_VW = 16;
	localparam int unsigned QI_S  = 37;
	localparam int unsigned QI_MW = 29;
	localparam int unsigned QI_PW = QI_VW + QI_MW;
	localparam logic [QI_MW-1:0] QI_M =
		QI_MW'(((64'(Y400_MUL) << QI_S) + 64'(DAYS_4000Y) - 64'd1) / 64'(DAYS_4000Y));
	// 80*l / 2447
	localparam int unsigned QJ_VW = 9;
	localparam int unsigned QJ_S  = 21;
	localparam int unsigned QJ_MW = 17;
	localparam int unsigned QJ_PW = QJ_VW + QJ_MW;
	localparam logic [QJ_MW-1:0] QJ_M =
		QJ_MW'(((64'(MONTH_NUM) << QJ_S) + 64'(MONTH_DEN) - 64'd1) / 64'(MONTH_DEN));
	// v / 100 for 13-bit v
	localparam int unsigned QY_VW = 13;
	localparam int unsigned QY_S  = 20;
	localparam int unsigned QY_MW = 14;
	localparam int unsigned QY_PW = QY_VW + QY_MW;
	localparam logic [QY_MW-1:0] QY_M =
		QY_MW'(((64'd1 << QY_S) + 64'(CENTURY) - 64'd1) / 64'(CENTURY));

	// floor(367 * (m - 2 - 12*adj) / 12) for every 4-bit month code
	function automatic logic [8:0] month_days(input logic [MON_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd305;
			4'd1:    r = 9'd336;
			4'd2:    r = 9'd367;
			4'd3:    r = 9'd30;
			4'd4:    r = 9'd61;
			4'd5:    r = 9'd91;
			4'd6:    r = 9'd122;
			4'd7:    r = 9'd152;
			4'd8:    r = 9'd183;
			4'd9:    r = 9'd214;
			4'd10:   r = 9'd244;
			4'd11:   r = 9'd275;
			4'd12:   r = 9'd305;
			4'd13:   r = 9'd336;
			4'd14:   r = 9'd367;
			4'd15:   r = 9'd397;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// floor(2447 * j / 80); j never exceeds 12 in decode
	function automatic logic [8:0] month_start(input logic [4:0] j);
		logic [8:0] r;
		case (j)
			5'd0:    r = 9'd0;
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd152;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd305;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/gmc_req_if.sv =====
`default_nettype none

interface gmc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [gmc_pkg::YEAR_W-1:0]  in_year;
	logic [gmc_pkg::MON_W-1:0]   in_month;
	logic [gmc_pkg::DAY_W-1:0]   in_day;
	logic [gmc_pkg::HOUR_W-1:0]  in_hour;
	logic [gmc_pkg::MIN_W-1:0]   in_minute;
	logic [gmc_pkg::CNT_W-1:0]   in_minutes;

	modport source (
		output valid, operation, in_year, in_month, in_day, in_hour, in_minute, in_minutes,
		input  ready
	);
	modport sink (
		input  valid, operation, in_year, in_month, in_day, in_hour, in_minute, in_minutes,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/gmc_rsp_if.sv =====
`default_nettype none

interface gmc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [gmc_pkg::CNT_W-1:0]   out_minutes;
	logic [gmc_pkg::YEAR_W-1:0]  out_year;
	logic [gmc_pkg::MON_W-1:0]   out_month;
	logic [gmc_pkg::DAY_W-1:0]   out_day;
	logic                        leap_year;

	modport source (
		output valid, out_minutes, out_year, out_month, out_day, leap_year,
		input  ready
	);
	modport sink (
		input  valid, out_minutes, out_year, out_month, out_day, leap_year,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/gmc_pipe_ctl.sv =====
`default_nettype none

module gmc_pipe_ctl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	input  logic              out_ready,
	output logic              in_ready,
	output gmc_pkg::gmc_ctl_t ctl
);

	logic [gmc_pkg::NSTG-1:0] vld_q;
	logic [gmc_pkg::NSTG-1:0] op_q;
	logic [gmc_pkg::NSTG-1:0] rdy;
	logic [gmc_pkg::NSTG-1:0] vld_up;
	logic [gmc_pkg::NSTG-1:0] op_up;

	// A stage may load when it is empty or its content moves on
	always_comb begin
		rdy[gmc_pkg::NSTG-1] = !vld_q[gmc_pkg::NSTG-1] || out_ready;
		for (int k = gmc_pkg::NSTG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign vld_up = {vld_q[gmc_pkg::NSTG-2:0], in_valid};
	assign op_up  = {op_q[gmc_pkg::NSTG-2:0], in_op};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < gmc_pkg::NSTG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_up[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < gmc_pkg::NSTG; k++) begin
			if (rdy[k]) begin
				op_q[k] <= op_up[k];
			end
		end
	end

	assign in_ready      = rdy[0];
	assign ctl.adv       = rdy;
	assign ctl.out_valid = vld_q[gmc_pkg::NSTG-1];
	assign ctl.out_op    = op_q[gmc_pkg::NSTG-1];

endmodule

`default_nettype wire

// ===== hdl/gmc_enc.sv =====
`default_nettype none

module gmc_enc (
	input  logic                       clk,
	input  gmc_pkg::gmc_ctl_t          ctl,
	input  logic [gmc_pkg::YEAR_W-1:0] year,
	input  logic [gmc_pkg::MON_W-1:0]  month,
	input  logic [gmc_pkg::DAY_W-1:0]  day,
	input  logic [gmc_pkg::HOUR_W-1:0] hour,
	input  logic [gmc_pkg::MIN_W-1:0]  minute,
	output logic [gmc_pkg::CNT_W-1:0]  minutes
);

	localparam int unsigned YW = gmc_pkg::YEAR_W;
	localparam int unsigned AW = YW + 1;
	localparam int unsigned PW = 24;
	localparam int unsigned DW = 25;
	localparam int unsigned CW = gmc_pkg::CNT_W;

	// Stage 1: year offsets and month term
	logic          early;
	logic [AW-1:0] a_diff, v_diff, a_mag, v_mag;

	assign early  = (month <= 4'd2);
	assign a_diff = {1'b0, year} - AW'(gmc_pkg::EPOCH_YEAR) - AW'(early);
	assign v_diff = {1'b0, year} - AW'(gmc_pkg::CENT_YEAR) - AW'(early);
	assign a_mag  = a_diff[AW-1] ? (~a_diff + AW'(1)) : a_diff;
	assign v_mag  = v_diff[AW-1] ? (~v_diff + AW'(1)) : v_diff;

	logic                       signa_s1, signv_s1;
	logic [YW-1:0]              absa_s1, absv_s1;
	logic [8:0]                 q_s1;
	logic [gmc_pkg::DAY_W-1:0]  day_s1;
	logic [gmc_pkg::HOUR_W-1:0] hour_s1;
	logic [gmc_pkg::MIN_W-1:0]  min_s1;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			signa_s1 <= a_diff[AW-1];
			signv_s1 <= v_diff[AW-1];
			absa_s1  <= a_mag[YW-1:0];
			absv_s1  <= v_mag[YW-1:0];
			q_s1     <= gmc_pkg::month_days(month);
			day_s1   <= day;
			hour_s1  <= hour;
			min_s1   <= minute;
		end
	end

	// Stage 2: 1461*|A| / 4 and |V| times the reciprocal of 100
	logic [PW-1:0] pa_full;
	assign pa_full = PW'(absa_s1) * PW'(gmc_pkg::DAYS_4Y);

	logic                          signa_s2, signv_s2;
	logic [PW-3:0]                 pa_s2;
	logic [gmc_pkg::QY_PW-1:0]     vp_s2;
	logic [8:0]                    q_s2;
	logic [gmc_pkg::DAY_W-1:0]     day_s2;
	logic [gmc_pkg::HOUR_W-1:0]    hour_s2;
	logic [gmc_pkg::MIN_W-1:0]     min_s2;

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			signa_s2 <= signa_s1;
			signv_s2 <= signv_s1;
			pa_s2    <= pa_full[PW-1:2];
			vp_s2    <= gmc_pkg::QY_PW'(absv_s1) * gmc_pkg::QY_PW'(gmc_pkg::QY_M);
			q_s2     <= q_s1;
			day_s2   <= day_s1;
			hour_s2  <= hour_s1;
			min_s2   <= min_s1;
		end
	end

	// Stage 3: restore the sign of the year term, take the century count
	localparam int unsigned QYW = gmc_pkg::QY_PW - gmc_pkg::QY_S;

	logic [PW-2:0]              p_s3;
	logic [QYW-1:0]             c_s3;
	logic                       signv_s3;
	logic [8:0]                 q_s3;
	logic [gmc_pkg::DAY_W-1:0]  day_s3;
	logic [gmc_pkg::HOUR_W-1:0] hour_s3;
	logic [gmc_pkg::MIN_W-1:0]  min_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			p_s3     <= signa_s2 ? (~{1'b0, pa_s2} + (PW-1)'(1)) : {1'b0, pa_s2};
			c_s3     <= vp_s2[gmc_pkg::QY_PW-1:gmc_pkg::QY_S];
			signv_s3 <= signv_s2;
			q_s3     <= q_s2;
			day_s3   <= day_s2;
			hour_s3  <= hour_s2;
			min_s3   <= min_s2;
		end
	end

	// Stage 4: day number
	logic [QYW+1:0] r3;
	logic [QYW-1:0] r;
	logic [DW-1:0]  cent_term;
	logic [DW-1:0]  days;

	assign r3        = (QYW+2)'(c_s3) * (QYW+2)'(3);
	assign r         = r3[QYW+1:2];
	assign cent_term = signv_s3 ? DW'(r) : (~DW'(r) + DW'(1));
	assign days      = {{(DW-PW+1){p_s3[PW-2]}}, p_s3} + DW'(q_s3) + DW'(day_s3)
	                 - DW'(gmc_pkg::DAY_OFFSET) + cent_term;

	logic [DW-1:0]              days_s4;
	logic [gmc_pkg::HOUR_W-1:0] hour_s4;
	logic [gmc_pkg::MIN_W-1:0]  min_s4;

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			days_s4 <= days;
			hour_s4 <= hour_s3;
			min_s4  <= min_s3;
		end
	end

	// Stage 5: scale to minutes, keep the low count bits
	logic [CW-1:0] days_x;
	logic [CW-1:0] tot;

	assign days_x = {{(CW-DW){days_s4[DW-1]}}, days_s4};
	assign tot    = days_x * CW'(gmc_pkg::MIN_PER_DAY)
	              + CW'(hour_s4) * CW'(gmc_pkg::MIN_PER_HOUR) + CW'(min_s4);

	logic [CW-1:0] tot_s5, tot_s6, tot_s7, tot_s8, tot_s9, tot_s10;

	// Stages 6 to 10: hold the count alongside the decode lane
	always_ff @(posedge clk) begin
		if (ctl.adv[4]) tot_s5  <= tot;
		if (ctl.adv[5]) tot_s6  <= tot_s5;
		if (ctl.adv[6]) tot_s7  <= tot_s6;
		if (ctl.adv[7]) tot_s8  <= tot_s7;
		if (ctl.adv[8]) tot_s9  <= tot_s8;
		if (ctl.adv[9]) tot_s10 <= tot_s9;
	end

	assign minutes = tot_s10;

endmodule

`default_nettype wire

// ===== hdl/gmc_dec.sv =====
`default_nettype none

module gmc_dec (
	input  logic                       clk,
	input  gmc_pkg::gmc_ctl_t          ctl,
	input  logic [gmc_pkg::CNT_W-1:0]  count,
	output logic [gmc_pkg::YEAR_W-1:0] year,
	output logic [gmc_pkg::MON_W-1:0]  month,
	output logic [gmc_pkg::DAY_W-1:0]  day,
	output logic                       leap
);

	localparam int unsigned LW  = gmc_pkg::QN_VW;
	localparam int unsigned L2W = gmc_pkg::QI_VW;
	localparam int unsigned L3W = gmc_pkg::QJ_VW;
	localparam int unsigned NW  = gmc_pkg::QN_PW - gmc_pkg::QN_S;
	localparam int unsigned IW  = gmc_pkg::QI_PW - gmc_pkg::QI_S;
	localparam int unsigned JW  = gmc_pkg::QJ_PW - gmc_pkg::QJ_S;
	localparam int unsigned CYW = gmc_pkg::QY_PW - gmc_pkg::QY_S;
	localparam int unsigned YW  = gmc_pkg::YEAR_W;
	localparam int unsigned NDW = 23;
	localparam int unsigned TIW = 19;

	// Stage 1: (count >> 5) times the reciprocal of 45
	logic [gmc_pkg::Q45_PW-1:0] p1_s1;

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			p1_s1 <= gmc_pkg::Q45_PW'(count[gmc_pkg::CNT_W-1:gmc_pkg::DAY_SHIFT])
			       * gmc_pkg::Q45_PW'(gmc_pkg::Q45_M);
		end
	end

	// Stage 2: biased day number
	logic [LW-1:0] l_s2;

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			l_s2 <= LW'(p1_s1[gmc_pkg::Q45_PW-1:gmc_pkg::Q45_S]) + LW'(gmc_pkg::JD_BIAS);
		end
	end

	// Stage 3: 400-year cycle quotient product
	logic [gmc_pkg::QN_PW-1:0] p2_s3;
	logic [LW-1:0]             l_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			p2_s3 <= gmc_pkg::QN_PW'(l_s2) * gmc_pkg::QN_PW'(gmc_pkg::QN_M);
			l_s3  <= l_s2;
		end
	end

	// Stage 4: cycle count and day within the cycle
	logic [NW-1:0]  n;
	logic [NDW-1:0] nd;
	logic [LW-1:0]  l2_full;

	assign n       = p2_s3[gmc_pkg::QN_PW-1:gmc_pkg::QN_S];
	assign nd      = NDW'(n) * NDW'(gmc_pkg::DAYS_400Y) + NDW'(3);
	assign l2_full = l_s3 - LW'(nd[NDW-1:2]);

	logic [NW-1:0]  n_s4;
	logic [L2W-1:0] l2_s4;

	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			n_s4  <= n;
			l2_s4 <= l2_full[L2W-1:0];
		end
	end

	// Stage 5: year-within-cycle quotient product
	logic [L2W-1:0] l2_inc;
	assign l2_inc = l2_s4 + L2W'(1);

	logic [gmc_pkg::QI_PW-1:0] p3_s5;
	logic [L2W-1:0]            l2_s5;
	logic [NW-1:0]             n_s5;

	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			p3_s5 <= gmc_pkg::QI_PW'(l2_inc) * gmc_pkg::QI_PW'(gmc_pkg::QI_M);
			l2_s5 <= l2_s4;
			n_s5  <= n_s4;
		end
	end

	// Stage 6: year within cycle and shifted day of year
	logic [IW-1:0]  i;
	logic [TIW-1:0] ti;
	logic [L2W-1:0] l3_full;

	assign i       = p3_s5[gmc_pkg::QI_PW-1:gmc_pkg::QI_S];
	assign ti      = TIW'(i) * TIW'(gmc_pkg::DAYS_4Y);
	assign l3_full = l2_s5 - L2W'(ti[TIW-1:2]) + L2W'(gmc_pkg::DAY_BIAS);

	logic [IW-1:0]  i_s6;
	logic [L3W-1:0] l3_s6;
	logic [NW-1:0]  n_s6;

	always_ff @(posedge clk) begin
		if (ctl.adv[5]) begin
			i_s6  <= i;
			l3_s6 <= l3_full[L3W-1:0];
			n_s6  <= n_s5;
		end
	end

	// Stage 7: month index product
	logic [gmc_pkg::QJ_PW-1:0] p4_s7;
	logic [L3W-1:0]            l3_s7;
	logic [IW-1:0]             i_s7;
	logic [NW-1:0]             n_s7;

	always_ff @(posedge clk) begin
		if (ctl.adv[6]) begin
			p4_s7 <= gmc_pkg::QJ_PW'(l3_s6) * gmc_pkg::QJ_PW'(gmc_pkg::QJ_M);
			l3_s7 <= l3_s6;
			i_s7  <= i_s6;
			n_s7  <= n_s6;
		end
	end

	// Stage 8: day, month and year
	logic [JW-1:0]  j;
	logic [1:0]     k;
	logic [L3W-1:0] d_full;
	logic [JW-1:0]  m_full;
	logic [YW:0]    y_full;

	assign j = p4_s7[gmc_pkg::QJ_PW-1:gmc_pkg::QJ_S];

	always_comb begin
		if (j >= JW'(2 * gmc_pkg::MONTH_WRAP)) begin
			k = 2'd2;
		end else if (j >= JW'(gmc_pkg::MONTH_WRAP)) begin
			k = 2'd1;
		end else begin
			k = 2'd0;
		end
	end

	assign d_full = l3_s7 - L3W'(gmc_pkg::month_start(j));
	assign m_full = j + JW'(2) - JW'(k) * JW'(gmc_pkg::YEAR_MONTHS);
	assign y_full = (YW+1)'(n_s7) * (YW+1)'(gmc_pkg::CENTURY) + (YW+1)'(gmc_pkg::DEC_YEAR_BASE)
	              + (YW+1)'(i_s7) + (YW+1)'(k);

	logic [YW-1:0]             yr_s8;
	logic [gmc_pkg::MON_W-1:0] mo_s8;
	logic [gmc_pkg::DAY_W-1:0] dy_s8;

	always_ff @(posedge clk) begin
		if (ctl.adv[7]) begin
			yr_s8 <= y_full[YW-1:0];
			mo_s8 <= m_full[gmc_pkg::MON_W-1:0];
			dy_s8 <= d_full[gmc_pkg::DAY_W-1:0];
		end
	end

	// Stage 9: century product for the leap test
	logic [gmc_pkg::QY_PW-1:0] yp_s9;
	logic [YW-1:0]             yr_s9;
	logic [gmc_pkg::MON_W-1:0] mo_s9;
	logic [gmc_pkg::DAY_W-1:0] dy_s9;

	always_ff @(posedge clk) begin
		if (ctl.adv[8]) begin
			yp_s9 <= gmc_pkg::QY_PW'(yr_s8) * gmc_pkg::QY_PW'(gmc_pkg::QY_M);
			yr_s9 <= yr_s8;
			mo_s9 <= mo_s8;
			dy_s9 <= dy_s8;
		end
	end

	// Stage 10: leap flag
	logic [CYW-1:0] cq;
	logic [YW-1:0]  crem;
	logic           leap_d;

	assign cq     = yp_s9[gmc_pkg::QY_PW-1:gmc_pkg::QY_S];
	assign crem   = yr_s9 - YW'(cq) * YW'(gmc_pkg::CENTURY);
	assign leap_d = (crem == '0) ? (cq[1:0] == 2'd0) : (yr_s9[1:0] == 2'd0);

	logic [YW-1:0]             yr_s10;
	logic [gmc_pkg::MON_W-1:0] mo_s10;
	logic [gmc_pkg::DAY_W-1:0] dy_s10;
	logic                      leap_s10;

	always_ff @(posedge clk) begin
		if (ctl.adv[9]) begin
			yr_s10   <= yr_s9;
			mo_s10   <= mo_s9;
			dy_s10   <= dy_s9;
			leap_s10 <= leap_d;
		end
	end

	assign year  = yr_s10;
	assign month = mo_s10;
	assign day   = dy_s10;
	assign leap  = leap_s10;

endmodule

`default_nettype wire

// ===== hdl/gregorian_minute_count_converter_unit.sv =====
// Throughput: one item per cycle while the output is not stalled; the 10-stage pipeline then moves an item every cycle.
// A stalled result holds while the stages behind it keep filling empty slots.
// Reset (arst_n low) clears the stage valid bits at once; the data registers are not reset.
`default_nettype none

module gregorian_minute_count_converter_unit (
	input logic        clk,
	input logic        arst_n,
	gmc_req_if.sink    req,
	gmc_rsp_if.source  rsp
);

	// Pipeline control: valid and operation bits per stage, per-stage load enables.
	// A stage loads when it is empty or its item moves on, so bubbles close up
	// behind a stalled result.
	gmc_pkg::gmc_ctl_t ctl;

	gmc_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_op     (req.operation),
		.out_ready (rsp.ready),
		.in_ready  (req.ready),
		.ctl       (ctl)
	);

	// Encode lane: date and time to minute count. Both lanes see every item;
	// the operation bit that travels with the item selects the result.
	logic [gmc_pkg::CNT_W-1:0] enc_minutes;

	gmc_enc u_enc (
		.clk     (clk),
		.ctl     (ctl),
		.year    (req.in_year),
		.month   (req.in_month),
		.day     (req.in_day),
		.hour    (req.in_hour),
		.minute  (req.in_minute),
		.minutes (enc_minutes)
	);

	// Decode lane: minute count to year, month, day and leap flag.
	logic [gmc_pkg::YEAR_W-1:0] dec_year;
	logic [gmc_pkg::MON_W-1:0]  dec_month;
	logic [gmc_pkg::DAY_W-1:0]  dec_day;
	logic                       dec_leap;

	gmc_dec u_dec (
		.clk   (clk),
		.ctl   (ctl),
		.count (req.in_minutes),
		.year  (dec_year),
		.month (dec_month),
		.day   (dec_day),
		.leap  (dec_leap)
	);

	// Result select: encode gives fixed date fields, decode gives a zero count.
	logic is_dec;
	assign is_dec = (ctl.out_op == gmc_pkg::OP_DECODE);

	assign rsp.valid       = ctl.out_valid;
	assign rsp.out_minutes = is_dec ? '0 : enc_minutes;
	assign rsp.out_year    = is_dec ? dec_year : gmc_pkg::YEAR_W'(gmc_pkg::ENC_YEAR);
	assign rsp.out_month   = is_dec ? dec_month : gmc_pkg::MON_W'(1);
	assign rsp.out_day     = is_dec ? dec_day : gmc_pkg::DAY_W'(1);
	assign rsp.leap_year   = is_dec ? dec_leap : 1'b0;

endmodule

`default_nettype wire
